// ----- src/stt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Transposition table package
// Item, result, configuration and table entry types, shared codes.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MATE_VALUE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEEPEST_SEARCH = 2'd1;

  localparam logic [14:0] MATE_VALUE_RESET     = 15'd32000;
  localparam logic [7:0]  DEEPEST_SEARCH_RESET = 8'd64;

  typedef enum logic [1:0] {
    KIND_STORE       = 2'd0,
    KIND_PROBE_SCORE = 2'd1,
    KIND_PROBE_MOVE  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    BOUND_EXACT = 2'd0,
    BOUND_UPPER = 2'd1,
    BOUND_LOWER = 2'd2
  } bound_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [63:0]        position_key;
    logic [7:0]         ply_from_root;
    logic [7:0]         search_depth;
    logic signed [15:0] alpha_bound;
    logic signed [15:0] beta_bound;
    logic signed [15:0] eval_score;
    logic [1:0]         bound_type;
    logic [15:0]        move_code;
  } item_t;

  typedef struct packed {
    logic signed [15:0] result_score;
    logic               score_hit;
    logic [15:0]        result_move;
    logic               move_hit;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  typedef struct packed {
    logic [7:0]         depth;
    logic [1:0]         bound_type;
    logic signed [15:0] score;
    logic [15:0]        move;
  } entry_t;

  typedef struct packed {
    logic [63:0] key;
    entry_t      entry;
  } line_t;

endpackage
`default_nettype wire

// ----- src/stt_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Transposition table channels
// Valid/ready channels for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface stt_item_if;
  import stt_pkg::*;
  logic  valid;
  logic  ready;
  item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface stt_result_if;
  import stt_pkg::*;
  logic    valid;
  logic    ready;
  result_t result;
  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

interface stt_cfg_if;
  import stt_pkg::*;
  logic       valid;
  logic       ready;
  cfg_write_t write;
  modport source (output valid, output write, input ready);
  modport sink   (input valid, input write, output ready);
endinterface
`default_nettype wire

// ----- src/search_transposition_table_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Search transposition table
// Direct-mapped table of search results with mate score rebasing.
// ----------------------------------------------------------------------------
// A probe result is registered in stage 1 and then in the output register.
// Throughput: one item per cycle while results are taken, set by the single
// table read port and the one-entry write forwarding register.
// Reset: a clearing pass writes zero to all 2^INDEX_BITS entries, one per
// cycle; no item is accepted until it ends. Configuration is taken throughout.
module search_transposition_table_top #(
  parameter int unsigned INDEX_BITS = 12
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  stt_item_if.sink    in_i,
  stt_cfg_if.sink     cfg_i,
  stt_result_if.source res_o
);
  import stt_pkg::*;

  localparam int unsigned DEPTH = 1 << INDEX_BITS;

  line_t mem [DEPTH];

  logic [14:0] mate_q;
  logic [7:0]  deep_q;

  logic                  clr_busy_q;
  logic [INDEX_BITS-1:0] clr_idx_q;

  logic                  s1_valid_q;
  item_t                 s1_item_q;
  line_t                 rd_q;
  logic                  fwd_valid_q;
  logic [INDEX_BITS-1:0] fwd_idx_q;
  line_t                 fwd_line_q;

  logic    out_valid_q;
  result_t out_q;

  logic                  in_accept;
  logic [INDEX_BITS-1:0] in_idx;
  logic [INDEX_BITS-1:0] s1_idx;
  line_t                 line;
  logic                  s1_store;
  logic                  s1_probe;
  logic                  s1_done;
  logic                  store_we;
  line_t                 new_line;
  result_t               res_d;
  logic signed [16:0]    mate_lim;
  logic signed [15:0]    probe_v;
  logic                  key_match;
  logic                  depth_ok;

  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  line_t                 mem_wdata;

  function automatic logic is_mate(logic signed [15:0] s, logic signed [16:0] lim);
    logic signed [16:0] ext;
    logic signed [16:0] mag;
    ext = {s[15], s};
    mag = ext[16] ? -ext : ext;
    return mag >= lim;
  endfunction

  // up: shift for storing, else rebase for probing
  function automatic logic signed [15:0] shift_mate(logic signed [15:0] s,
                                                    logic [7:0] ply,
                                                    logic signed [16:0] lim,
                                                    logic up);
    logic signed [17:0] ext;
    logic signed [17:0] p;
    logic signed [17:0] sum;
    logic               add;
    ext = {{2{s[15]}}, s};
    p   = $signed({10'b0, ply});
    add = (s > 16'sd0) == up;
    sum = add ? ext + p : ext - p;
    if (!is_mate(s, lim)) begin
      return s;
    end else if (sum > 18'sd32767) begin
      return 16'sh7fff;
    end else if (sum < -18'sd32768) begin
      return 16'sh8000;
    end else begin
      return sum[15:0];
    end
  endfunction

  assign mate_lim = $signed({2'b00, mate_q}) - $signed({9'b0, deep_q});

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mate_q <= MATE_VALUE_RESET;
      deep_q <= DEEPEST_SEARCH_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.write.index)
        CFG_MATE_VALUE:     mate_q <= cfg_i.write.data[14:0];
        CFG_DEEPEST_SEARCH: deep_q <= cfg_i.write.data[7:0];
        default: ;
      endcase
    end
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (&clr_idx_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // pipeline control
  assign in_idx    = in_i.item.position_key[INDEX_BITS-1:0];
  assign s1_idx    = s1_item_q.position_key[INDEX_BITS-1:0];
  assign s1_store  = s1_item_q.kind == KIND_STORE;
  assign s1_probe  = (s1_item_q.kind == KIND_PROBE_SCORE) ||
                     (s1_item_q.kind == KIND_PROBE_MOVE);
  assign s1_done   = s1_valid_q && (!s1_probe || !out_valid_q || res_o.ready);
  assign store_we  = s1_done && s1_store;
  assign in_i.ready = !clr_busy_q && (!s1_valid_q || s1_done);
  assign in_accept = in_i.valid && in_i.ready;

  // forward the write that lands in the same cycle as this item's read
  assign line = (fwd_valid_q && (fwd_idx_q == s1_idx)) ? fwd_line_q : rd_q;

  always_comb begin
    new_line.key              = s1_item_q.position_key;
    new_line.entry.move       = s1_item_q.move_code;
    new_line.entry.score      = shift_mate(s1_item_q.eval_score,
                                           s1_item_q.ply_from_root, mate_lim, 1'b1);
    new_line.entry.bound_type = s1_item_q.bound_type;
    new_line.entry.depth      = s1_item_q.search_depth;
  end

  assign key_match = line.key == s1_item_q.position_key;
  assign depth_ok  = line.entry.depth >= s1_item_q.search_depth;
  assign probe_v   = shift_mate(line.entry.score, s1_item_q.ply_from_root, mate_lim, 1'b0);

  always_comb begin
    res_d = '0;
    if (s1_item_q.kind == KIND_PROBE_SCORE) begin
      if (key_match && depth_ok) begin
        unique case (line.entry.bound_type)
          BOUND_EXACT: begin
            res_d.score_hit    = 1'b1;
            res_d.result_score = probe_v;
          end
          BOUND_UPPER: begin
            if (probe_v <= s1_item_q.alpha_bound) begin
              res_d.score_hit    = 1'b1;
              res_d.result_score = s1_item_q.alpha_bound;
            end
          end
          BOUND_LOWER: begin
            if (probe_v >= s1_item_q.beta_bound) begin
              res_d.score_hit    = 1'b1;
              res_d.result_score = s1_item_q.beta_bound;
            end
          end
          default: ;
        endcase
      end
    end else if (key_match) begin
      res_d.move_hit    = 1'b1;
      res_d.result_move = line.entry.move;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= store_we;
      end else if (s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_done && s1_probe) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q  <= in_i.item;
      fwd_idx_q  <= s1_idx;
      fwd_line_q <= new_line;
    end
    if (s1_done && s1_probe) begin
      out_q <= res_d;
    end
  end

  // table memory
  assign mem_we    = clr_busy_q || store_we;
  assign mem_waddr = clr_busy_q ? clr_idx_q : s1_idx;
  assign mem_wdata = clr_busy_q ? line_t'('0) : new_line;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_q <= mem[in_idx];
    end
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.result = out_q;

`ifndef SYNTHESIS
  a_no_item_while_clearing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!in_i.ready && !s1_valid_q))
    else $error("item in flight during clearing pass");

  a_result_from_probe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q && s1_probe))
    else $error("result without a probe");

  a_single_hit_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.score_hit && out_q.move_hit))
    else $error("score and move hit together");

  a_store_leaves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_store) |-> s1_done)
    else $error("store held in stage");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// Transposition table testbench
// Drives stores, score probes and move probes through the item channel,
// switches the mate settings between phases and checks every probe reply
// against a cycle-free model of the table kept in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb;
  import stt_pkg::*;

  localparam int unsigned INDEX_BITS      = 12;
  localparam int unsigned TABLE_SIZE      = 1 << INDEX_BITS;
  localparam int          STALL_LIMIT     = 20000;
  localparam int          DRAIN_CYCLES    = 10;
  localparam int          LONG_HOLD       = 400;
  localparam int          HOLD_AFTER      = 40;
  localparam int          PHASES          = 7;
  localparam int          ITEMS_PER_PHASE = 57;
  localparam int          POOL_DEPTH      = 64;

  localparam logic [1:0]           KIND_UNUSED  = 2'd3;
  localparam logic [1:0]           BOUND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  class probe_scoreboard;
    logic [63:0] slot_keys [TABLE_SIZE];
    entry_t      slots [TABLE_SIZE];
    logic [14:0] mate_value;
    logic [7:0]  deepest_search;
    result_t     pending [$];
    int          mismatches;

    function new();
      foreach (slot_keys[i]) begin
        slot_keys[i] = '0;
        slots[i]     = '0;
      end
      mate_value     = MATE_VALUE_RESET;
      deepest_search = DEEPEST_SEARCH_RESET;
      mismatches     = 0;
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_MATE_VALUE) mate_value = data[14:0];
      else if (idx == CFG_DEEPEST_SEARCH) deepest_search = data[7:0];
    endfunction

    // shift a mate score by the ply: away from the root on store, back on probe
    function int rebase(int s, int ply, bit storing);
      int mag;
      int v;
      mag = (s < 0) ? -s : s;
      if (mag < int'(mate_value) - int'(deepest_search)) return s;
      v = ((s > 0) == storing) ? s + ply : s - ply;
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void note_item(item_t it);
      logic [INDEX_BITS-1:0] idx;
      entry_t                e;
      result_t               r;
      logic                  match;
      int                    v;
      idx   = it.position_key[INDEX_BITS-1:0];
      e     = slots[idx];
      match = (slot_keys[idx] == it.position_key);
      r     = '0;
      case (it.kind)
        KIND_STORE: begin
          v = rebase($signed(it.eval_score), it.ply_from_root, 1'b1);
          slot_keys[idx] = it.position_key;
          slots[idx] = '{depth: it.search_depth, bound_type: it.bound_type,
                         score: v[15:0], move: it.move_code};
        end
        KIND_PROBE_SCORE: begin
          if (match && e.depth >= it.search_depth) begin
            v = rebase($signed(e.score), it.ply_from_root, 1'b0);
            case (e.bound_type)
              BOUND_EXACT: begin
                r.score_hit    = 1'b1;
                r.result_score = v[15:0];
              end
              BOUND_UPPER: begin
                if (v <= $signed(it.alpha_bound)) begin
                  r.score_hit    = 1'b1;
                  r.result_score = it.alpha_bound;
                end
              end
              BOUND_LOWER: begin
                if (v >= $signed(it.beta_bound)) begin
                  r.score_hit    = 1'b1;
                  r.result_score = it.beta_bound;
                end
              end
              default: ;
            endcase
          end
          pending.push_back(r);
        end
        KIND_PROBE_MOVE: begin
          if (match) begin
            r.move_hit    = 1'b1;
            r.result_move = e.move;
          end
          pending.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reply: score %0d hit %0b move %h hit %0b",
                   $signed(got.result_score), got.score_hit, got.result_move, got.move_hit);
        return;
      end
      exp = pending.pop_front();
      if (got.result_score !== exp.result_score || got.score_hit !== exp.score_hit ||
          got.result_move !== exp.result_move || got.move_hit !== exp.move_hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d/%0b/%h/%0b got %0d/%0b/%h/%0b",
                   $signed(exp.result_score), exp.score_hit, exp.result_move, exp.move_hit,
                   $signed(got.result_score), got.score_hit, got.result_move, got.move_hit);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  stt_item_if   in_if ();
  stt_cfg_if    cfg_if ();
  stt_result_if res_if ();

  search_transposition_table_top #(.INDEX_BITS(INDEX_BITS)) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  probe_scoreboard board;
  item_t           stored_items [$];
  int              send_calm   = 0;
  int              idle_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int pick_gap(ref int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic signed [15:0] to_score(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic item_t build(logic [1:0] kind, logic [63:0] key, logic [7:0] ply,
                                  logic [7:0] depth, int alpha, int beta, int score,
                                  logic [1:0] bt, logic [15:0] move);
    item_t it;
    it.kind          = kind;
    it.position_key  = key;
    it.ply_from_root = ply;
    it.search_depth  = depth;
    it.alpha_bound   = to_score(alpha);
    it.beta_bound    = to_score(beta);
    it.eval_score    = to_score(score);
    it.bound_type    = bt;
    it.move_code     = move;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    item_t past;
    int    r;
    int    off;
    int    mag;
    int    band;
    bit    have_past;
    it = '0;
    r  = $urandom_range(0, 99);
    if (r < 5) it.kind = KIND_UNUSED;
    else if (r < 40) it.kind = KIND_STORE;
    else if (r < 82) it.kind = KIND_PROBE_SCORE;
    else it.kind = KIND_PROBE_MOVE;
    it.position_key  = {$urandom, $urandom};
    it.ply_from_root = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 20)) : 8'($urandom);
    it.search_depth  = 8'($urandom);
    it.alpha_bound   = 16'($urandom);
    it.beta_bound    = 16'($urandom);
    it.move_code     = 16'($urandom);
    it.bound_type    = ($urandom_range(0, 9) == 0) ? BOUND_UNUSED : 2'($urandom_range(0, 2));
    band = int'(board.mate_value) - int'(board.deepest_search);
    r    = $urandom_range(0, 9);
    if (r < 4) begin
      off = int'($urandom_range(0, 303)) - 3;
      mag = band + off;
      it.eval_score = to_score(($urandom_range(0, 1) != 0) ? -mag : mag);
    end else if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       it.eval_score = 16'sh7FFF;
        1:       it.eval_score = 16'sh8000;
        2:       it.eval_score = 16'sh0000;
        default: it.eval_score = 16'shFFFF;
      endcase
    end else begin
      it.eval_score = 16'($urandom);
    end

    have_past = (stored_items.size() != 0);
    if (have_past) past = stored_items[$urandom_range(0, stored_items.size() - 1)];
    r = $urandom_range(0, 99);
    if (it.kind == KIND_STORE) begin
      if (have_past && r < 45) it.position_key = past.position_key;
      else if (have_past && r < 55)
        it.position_key[INDEX_BITS-1:0] = past.position_key[INDEX_BITS-1:0];
      if ($urandom_range(0, 1) != 0) it.search_depth = 8'($urandom_range(100, 255));
      stored_items.push_back(it);
      if (stored_items.size() > POOL_DEPTH) void'(stored_items.pop_front());
    end else if (have_past && r < 88) begin
      it.position_key = past.position_key;
      if (r >= 75) it.position_key ^= 64'd1 << $urandom_range(INDEX_BITS, 63);
      if ($urandom_range(0, 1) != 0) begin
        off = int'($urandom_range(0, 80)) - 40;
        it.alpha_bound = to_score($signed(past.eval_score) + off);
        off = int'($urandom_range(0, 80)) - 40;
        it.beta_bound  = to_score($signed(past.eval_score) + off);
      end
      if ($urandom_range(0, 1) != 0) it.search_depth = 8'($urandom_range(0, past.search_depth));
    end
    return it;
  endfunction

  task automatic offer(input item_t it);
    int gap;
    gap = pick_gap(send_calm);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.item  <= it;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_item(it);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.write <= '{index: idx, data: data};
    do @(posedge clk_i); while (!cfg_if.ready);
    board.write_register(idx, data);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] mate_data,
                                input logic [CFG_DATA_W-1:0] depth_data);
    write_register(CFG_MATE_VALUE, mate_data);
    write_register(CFG_DEEPEST_SEARCH, depth_data);
    cfg_if.valid <= 1'b0;
  endtask

  // drain replies, then let trailing stores leave the pipeline
  task automatic wait_idle();
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    logic [63:0] k_a;
    logic [63:0] k_b;
    logic [63:0] k_c;
    logic [63:0] k_d;
    logic [63:0] k_e;
    logic [63:0] k_f;
    logic [63:0] k_alias;
    k_a     = 64'hFFFF_FFFF_FFFF_FFFF;
    k_b     = 64'h8000_0000_0000_0123;
    k_c     = 64'h0123_4567_89AB_C456;
    k_d     = 64'h0000_0000_0000_0789;
    k_e     = 64'h5555_AAAA_5555_0ABC;
    k_f     = 64'h7FFF_0000_0000_0DEF;
    k_alias = 64'h1000_0000_0000_0000;
    // fresh table: key zero hits the cleared entry
    offer(build(KIND_PROBE_SCORE, 64'd0, 8'd0, 8'd0, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_MOVE, 64'd0, 8'd0, 8'd0, 0, 0, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_SCORE, 64'd0, 8'd0, 8'd1, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_MOVE, k_alias, 8'd0, 8'd0, 0, 0, 0, BOUND_EXACT, 16'h0));
    // saturating mate shifts at the extremes
    offer(build(KIND_STORE, k_a, 8'd255, 8'd255, 0, 0, 32767, BOUND_EXACT, 16'hFFFF));
    offer(build(KIND_PROBE_SCORE, k_a, 8'd255, 8'd255, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_MOVE, k_a, 8'd0, 8'd0, 0, 0, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_STORE, k_b, 8'd200, 8'd0, 0, 0, -32768, BOUND_EXACT, 16'h0000));
    offer(build(KIND_PROBE_SCORE, k_b, 8'd0, 8'd0, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_SCORE, k_b, 8'd255, 8'd0, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    // mate band edge and depth check
    offer(build(KIND_STORE, k_c, 8'd10, 8'd20, 0, 0, 31950, BOUND_EXACT, 16'h1234));
    offer(build(KIND_PROBE_SCORE, k_c, 8'd3, 8'd20, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_SCORE, k_c, 8'd3, 8'd21, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    // upper and lower bounds on the window edges
    offer(build(KIND_STORE, k_d, 8'd5, 8'd8, 0, 0, 100, BOUND_UPPER, 16'h5A5A));
    offer(build(KIND_PROBE_SCORE, k_d, 8'd5, 8'd8, 100, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_SCORE, k_d, 8'd5, 8'd8, 99, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_STORE, k_e, 8'd7, 8'd8, 0, 0, -31936, BOUND_LOWER, 16'hA5A5));
    offer(build(KIND_PROBE_SCORE, k_e, 8'd7, 8'd8, -32768, -31936, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_PROBE_SCORE, k_e, 8'd7, 8'd8, -32768, -31935, 0, BOUND_EXACT, 16'h0));
    // unused bound type, then an ignored item kind
    offer(build(KIND_STORE, k_f, 8'd0, 8'd255, 0, 0, 0, BOUND_UNUSED, 16'h4321));
    offer(build(KIND_PROBE_SCORE, k_f, 8'd0, 8'd0, -32768, 32767, 0, BOUND_EXACT, 16'h0));
    offer(build(KIND_UNUSED, k_f, 8'd1, 8'd1, 0, 0, 5, BOUND_EXACT, 16'hBEEF));
    offer(build(KIND_PROBE_MOVE, k_f, 8'd0, 8'd0, 0, 0, 0, BOUND_EXACT, 16'h0));
    // just below the mate band: no shift
    offer(build(KIND_STORE, 64'd0, 8'd50, 8'd3, 0, 0, 31935, BOUND_EXACT, 16'h0F0F));
    offer(build(KIND_PROBE_SCORE, 64'd0, 8'd50, 8'd3, -32768, 32767, 0, BOUND_EXACT, 16'h0));
  endtask

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin : reply_sink
    int stall;
    int calm;
    int taken;
    calm         = 0;
    taken        = 0;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = (taken == HOLD_AFTER) ? LONG_HOLD : pick_gap(calm);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      board.check_result(res_if.result);
      taken++;
    end
  end

  initial begin : stimulus
    item_t it;
    int    count;
    board        = new();
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.item   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.write = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == 0) begin
        run_directed();
      end else begin
        in_if.valid <= 1'b0;
        wait_idle();
        case (phase)
          1: apply_settings(16'hFFFF, 16'hFFFF);
          2: apply_settings(16'h8000, 16'h0000);
          3: begin
            write_register(CFG_UNMAPPED, 16'($urandom));
            apply_settings(16'($urandom), 16'($urandom));
          end
          4: apply_settings(16'd100, {8'($urandom), 8'hFF});
          5: apply_settings(16'h7FFF, {8'($urandom), 8'h00});
          default: apply_settings({1'b0, MATE_VALUE_RESET}, {8'h00, DEEPEST_SEARCH_RESET});
        endcase
      end
      count = 0;
      while (count < ITEMS_PER_PHASE) begin
        it = random_item();
        offer(it);
        if (it.kind != KIND_UNUSED) count++;
      end
    end

    in_if.valid <= 1'b0;
    wait_idle();
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
